// ===== rtl/mkdb_pkg.sv =====
// ---------------------------------------------------------------------------
// mkdb_pkg
// Shared types, constants and register indexes of the multi-key debouncer.
// ---------------------------------------------------------------------------
package mkdb_pkg;

   localparam int NUM_KEYS    = 8;
   localparam int KEY_INDEX_W = 3;
   localparam int SLOT_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int STAMP_W     = 32;
   localparam int RUN_W       = 4;
   localparam int MS_W        = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_MS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_MS      = 2'd2;

   localparam logic [RUN_W-1:0] STABLE_COUNT_RESET = 4'd4;
   localparam logic [MS_W-1:0]  SHORT_MS_RESET     = 16'd50;
   localparam logic [MS_W-1:0]  LONG_MS_RESET      = 16'd500;

   typedef struct packed {
      logic [KEY_INDEX_W-1:0] key_index;
      logic                   raw_level;
      logic [STAMP_W-1:0]     now_ms;
   } req_word_type;

   typedef struct packed {
      logic [KEY_INDEX_W-1:0] key_id;
      logic                   clean_level;
      logic                   went_down;
      logic                   went_up;
      logic [STAMP_W-1:0]     press_ms;
      logic                   short_press;
      logic                   long_press;
   } rsp_word_type;

   // One key's state as kept in the state memory.
   typedef struct packed {
      logic               debounced;
      logic               prev_raw;
      logic [RUN_W-1:0]   stable_run;
      logic [STAMP_W-1:0] down_stamp;
   } key_entry_type;

   localparam key_entry_type KEY_ENTRY_RESET = '{
      debounced:  1'b1,
      prev_raw:   1'b0,
      stable_run: '0,
      down_stamp: '0
   };

endpackage

// ===== rtl/mkdb_key_update.sv =====
// ---------------------------------------------------------------------------
// mkdb_key_update
// Next state of one key and the result word for one raw sample.
// ---------------------------------------------------------------------------
module mkdb_key_update (
   input  mkdb_pkg::key_entry_type   entry,
   input  mkdb_pkg::req_word_type    req_word,
   input  logic [mkdb_pkg::RUN_W-1:0] stable_count,
   input  logic [mkdb_pkg::MS_W-1:0]  short_ms,
   input  logic [mkdb_pkg::MS_W-1:0]  long_ms,
   output mkdb_pkg::key_entry_type   entry_next,
   output mkdb_pkg::rsp_word_type    rsp_word
);
   import mkdb_pkg::*;

   logic             same_level;
   logic [RUN_W:0]   run_plus;
   logic             level_taken;
   logic             down;
   logic             up;
   logic [STAMP_W-1:0] press;
   logic [STAMP_W-1:0] short_ext;
   logic [STAMP_W-1:0] long_ext;

   assign same_level  = (req_word.raw_level == entry.prev_raw);
   assign run_plus    = {1'b0, entry.stable_run} + {{RUN_W{1'b0}}, 1'b1};
   // A count of zero behaves as one since run_plus is never below one.
   assign level_taken = same_level && (run_plus >= {1'b0, stable_count});
   assign down        = level_taken && entry.debounced && !req_word.raw_level;
   assign up          = level_taken && !entry.debounced && req_word.raw_level;
   assign press       = req_word.now_ms - entry.down_stamp;
   assign short_ext   = {{(STAMP_W-MS_W){1'b0}}, short_ms};
   assign long_ext    = {{(STAMP_W-MS_W){1'b0}}, long_ms};

   always_comb begin
      entry_next = entry;
      if (!same_level) begin
         entry_next.stable_run = '0;
         entry_next.prev_raw   = req_word.raw_level;
      end else if (!level_taken) begin
         entry_next.stable_run = run_plus[RUN_W-1:0];
      end else begin
         entry_next.stable_run = '0;
         entry_next.debounced  = req_word.raw_level;
         if (down) begin
            entry_next.down_stamp = req_word.now_ms;
         end
      end
   end

   always_comb begin
      rsp_word.key_id      = req_word.key_index;
      rsp_word.clean_level = entry_next.debounced;
      rsp_word.went_down   = down;
      rsp_word.went_up     = up;
      rsp_word.press_ms    = up ? press : '0;
      rsp_word.short_press = up && (short_ext < press) && (press < long_ext);
      rsp_word.long_press  = up && (press > long_ext);
   end

endmodule

// ===== rtl/multi_key_debounce_press_timer.sv =====
// ---------------------------------------------------------------------------
// multi_key_debounce_press_timer
// Per-key counter debouncer with press duration classing; key state is kept
// in a small synchronous memory and updated by read-modify-write.
// ---------------------------------------------------------------------------
//  Channel | Direction | Signals                         | Word moves when
//  req     | in        | req_valid, req_ready, req_word  | req_valid && req_ready
//  rsp     | out       | rsp_valid, rsp_ready, rsp_word  | rsp_valid && rsp_ready
//  csr     | in        | csr_valid, csr_ready, csr_index,| csr_valid (always ready)
//          |           | csr_wdata                       |
//
// One word per cycle while rsp is not stalled. The memory read and the request
// word are registered into the update stage at the accepting edge; the update
// result is then registered into the output register when that stage advances.
// A word for the key just written is served from a bypass of the last write.
// Reset marks every key entry as unwritten, so it reads as keys up with
// cleared counters; no clearing pass is needed. When rsp stalls, the update
// stage holds and req_ready drops once that stage is occupied.
// ---------------------------------------------------------------------------
module multi_key_debounce_press_timer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mkdb_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mkdb_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mkdb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mkdb_pkg::MS_W-1:0]            csr_wdata
);
   import mkdb_pkg::*;

   // Configuration registers.
   logic [RUN_W-1:0] stable_count_ff, stable_count_in;
   logic [MS_W-1:0]  short_ms_ff, short_ms_in;
   logic [MS_W-1:0]  long_ms_ff, long_ms_in;

   // State memory with one written flag per entry.
   key_entry_type    key_mem_ff [NUM_KEYS];
   logic [NUM_KEYS-1:0] written_ff, written_in;

   // Update stage.
   logic             s1_valid_ff, s1_valid_in;
   req_word_type     s1_word_ff;
   key_entry_type    rd_entry_ff;
   logic             rd_written_ff;

   // Last write, for the bypass.
   logic             wr_valid_ff, wr_valid_in;
   logic [SLOT_W-1:0] wr_slot_ff;
   key_entry_type    wr_entry_ff;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff;

   logic             req_take;
   logic             s1_advance;
   logic [SLOT_W-1:0] req_slot;
   logic [SLOT_W-1:0] s1_slot;
   key_entry_type    cur_entry;
   key_entry_type    next_entry;
   rsp_word_type     next_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      stable_count_in = stable_count_ff;
      short_ms_in     = short_ms_ff;
      long_ms_in      = long_ms_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STABLE_COUNT: stable_count_in = csr_wdata[RUN_W-1:0];
            CSR_SHORT_MS:     short_ms_in     = csr_wdata;
            CSR_LONG_MS:      long_ms_in      = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_count_ff <= STABLE_COUNT_RESET;
         short_ms_ff     <= SHORT_MS_RESET;
         long_ms_ff      <= LONG_MS_RESET;
      end else begin
         stable_count_ff <= stable_count_in;
         short_ms_ff     <= short_ms_in;
         long_ms_ff      <= long_ms_in;
      end
   end

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;
   assign req_slot   = SLOT_W'(req_word.key_index % NUM_KEYS);
   assign s1_slot    = SLOT_W'(s1_word_ff.key_index % NUM_KEYS);

   // The last write is always the newest copy of its entry.
   always_comb begin
      if (wr_valid_ff && (wr_slot_ff == s1_slot)) begin
         cur_entry = wr_entry_ff;
      end else if (rd_written_ff) begin
         cur_entry = rd_entry_ff;
      end else begin
         cur_entry = KEY_ENTRY_RESET;
      end
   end

   mkdb_key_update u_update (
      .entry        (cur_entry),
      .req_word     (s1_word_ff),
      .stable_count (stable_count_ff),
      .short_ms     (short_ms_ff),
      .long_ms      (long_ms_ff),
      .entry_next   (next_entry),
      .rsp_word     (next_rsp)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      wr_valid_in = wr_valid_ff || s1_advance;
      written_in  = written_ff;
      if (s1_advance) begin
         written_in[s1_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wr_valid_ff  <= 1'b0;
         written_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_valid_ff  <= wr_valid_in;
         written_ff   <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff    <= req_word;
         rd_entry_ff   <= key_mem_ff[req_slot];
         rd_written_ff <= written_ff[req_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         key_mem_ff[s1_slot] <= next_entry;
         wr_slot_ff          <= s1_slot;
         wr_entry_ff         <= next_entry;
         rsp_word_ff         <= next_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A press and a release are never reported on the same word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.went_down && rsp_word.went_up))
      else $error("press and release flagged together");

   // Duration classes appear only with a release and never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.short_press || rsp_word.long_press) |->
         rsp_word.went_up && !(rsp_word.short_press && rsp_word.long_press))
      else $error("press class without a single release");

   // Reported edges agree with the debounced level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.went_down || rsp_word.went_up) |->
         (rsp_word.clean_level == rsp_word.went_up))
      else $error("edge flag disagrees with debounced level");

   // An accepted word always lands in the update stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted word lost before update");

endmodule

// ===== test/mkdb_press_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mkdb_press_checker
// Watches the req, rsp and csr channels of the multi-key debouncer, keeps its
// own per-key debounce state, predicts one result word per accepted sample
// and compares every accepted result word with the oldest prediction.
// ---------------------------------------------------------------------------
module mkdb_press_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  mkdb_pkg::req_word_type           req_word,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  mkdb_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [mkdb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mkdb_pkg::MS_W-1:0]        csr_wdata,
   output int                               fail_count,
   output int                               pending_count
);
   import mkdb_pkg::*;

   // Predicted register settings.
   logic [RUN_W-1:0]   need_count;
   logic [MS_W-1:0]    short_limit;
   logic [MS_W-1:0]    long_limit;

   // Predicted per-key state.
   logic               key_level [NUM_KEYS];
   logic               key_last_raw [NUM_KEYS];
   logic [RUN_W-1:0]   key_run [NUM_KEYS];
   logic [STAMP_W-1:0] key_press_stamp [NUM_KEYS];

   rsp_word_type       predicted_rsp [$];
   int                 errors = 0;

   function automatic rsp_word_type debounce_sample(input req_word_type w);
      rsp_word_type   r;
      int unsigned    slot;
      logic [RUN_W:0] run_next;
      logic [STAMP_W-1:0] span;
      r    = '0;
      slot = w.key_index % NUM_KEYS;
      r.key_id = w.key_index;
      if (w.raw_level != key_last_raw[slot]) begin
         key_run[slot]      = '0;
         key_last_raw[slot] = w.raw_level;
      end else begin
         run_next = {1'b0, key_run[slot]} + 1'b1;
         if (run_next < {1'b0, need_count}) begin
            key_run[slot] = run_next[RUN_W-1:0];
         end else begin
            // Level accepted; an edge only when it differs from the clean level.
            key_run[slot] = '0;
            r.went_down = key_level[slot] & ~w.raw_level;
            r.went_up   = ~key_level[slot] & w.raw_level;
            key_level[slot] = w.raw_level;
            if (r.went_down) begin
               key_press_stamp[slot] = w.now_ms;
            end
            if (r.went_up) begin
               span          = w.now_ms - key_press_stamp[slot];
               r.press_ms    = span;
               r.short_press = (STAMP_W'(short_limit) < span) &&
                               (span < STAMP_W'(long_limit));
               r.long_press  = span > STAMP_W'(long_limit);
            end
         end
      end
      r.clean_level = key_level[slot];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         need_count  = STABLE_COUNT_RESET;
         short_limit = SHORT_MS_RESET;
         long_limit  = LONG_MS_RESET;
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_level[k]       = 1'b1;
            key_last_raw[k]    = 1'b0;
            key_run[k]         = '0;
            key_press_stamp[k] = '0;
         end
         predicted_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STABLE_COUNT: need_count  = csr_wdata[RUN_W-1:0];
               CSR_SHORT_MS:     short_limit = csr_wdata;
               CSR_LONG_MS:      long_limit  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(debounce_sample(req_word));
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected result word: key=%0d lvl=%0b dn=%0b up=%0b ms=%0d",
                           rsp_word.key_id, rsp_word.clean_level, rsp_word.went_down,
                           rsp_word.went_up, rsp_word.press_ms);
               end
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_word.key_id !== want.key_id ||
                   rsp_word.clean_level !== want.clean_level ||
                   rsp_word.went_down !== want.went_down ||
                   rsp_word.went_up !== want.went_up ||
                   rsp_word.press_ms !== want.press_ms ||
                   rsp_word.short_press !== want.short_press ||
                   rsp_word.long_press !== want.long_press) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch: expected key=%0d lvl=%0b dn=%0b up=%0b ms=%0d sh=%0b lg=%0b",
                              want.key_id, want.clean_level, want.went_down, want.went_up,
                              want.press_ms, want.short_press, want.long_press);
                     $display("          actual   key=%0d lvl=%0b dn=%0b up=%0b ms=%0d sh=%0b lg=%0b",
                              rsp_word.key_id, rsp_word.clean_level, rsp_word.went_down,
                              rsp_word.went_up, rsp_word.press_ms, rsp_word.short_press,
                              rsp_word.long_press);
                  end
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= predicted_rsp.size();
   end

endmodule

// ===== test/tb_multi_key_debounce_press_timer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multi_key_debounce_press_timer
// Drives key samples into the multi-key debouncer: a directed set of press
// and release sequences, then random bursts over several register settings
// with idling on both channels and one long result stall.
// ---------------------------------------------------------------------------
module tb_multi_key_debounce_press_timer;
   import mkdb_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASE_WORDS     = 190;
   localparam int LONG_HOLD       = 200;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [MS_W-1:0]        csr_wdata = '0;

   int fail_count;
   int pending_count;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_request = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int cycle_count = 0;

   // Stimulus copy of the settings, used to aim press durations at thresholds.
   int unsigned cur_count = 4;
   int unsigned cur_short = 50;
   int unsigned cur_long = 500;

   logic [STAMP_W-1:0] key_clock [NUM_KEYS];
   logic               key_drive [NUM_KEYS];

   multi_key_debounce_press_timer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mkdb_press_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: random idling, plus a long stall whenever one is requested.
   always @(negedge clock) begin
      if (hold_taken != hold_request) begin
         hold_taken = hold_request;
         hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   function automatic req_word_type key_sample(input int unsigned k, input logic lvl,
                                               input logic [STAMP_W-1:0] stamp);
      req_word_type w;
      w.key_index = k[KEY_INDEX_W-1:0];
      w.raw_level = lvl;
      w.now_ms    = stamp;
      return w;
   endfunction

   // Entered and left at a falling edge; valid stays high until the word moves.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Waits for the block to drain, then writes all registers, including the
   // unused index, which must be ignored.
   task automatic program_regs(input logic [RUN_W-1:0] sc, input logic [MS_W-1:0] sh,
                               input logic [MS_W-1:0] lg);
      logic [MS_W-1:0] data;
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         case (i[CSR_INDEX_W-1:0])
            CSR_STABLE_COUNT: data = {12'($urandom_range(0, 4095)), sc};
            CSR_SHORT_MS:     data = sh;
            CSR_LONG_MS:      data = lg;
            default:          data = 16'($urandom);
         endcase
         csr_valid <= 1'b1;
         csr_index <= i[CSR_INDEX_W-1:0];
         csr_wdata <= data;
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      cur_count = (sc == 0) ? 1 : sc;
      cur_short = sh;
      cur_long  = lg;
   endtask

   // Bursts of equal samples on random keys, each with a time jump at its start so
   // that press durations land around the thresholds; some words are noise.
   task automatic random_phase(input int words);
      int unsigned k;
      int unsigned len;
      logic        lvl;
      logic [STAMP_W-1:0] jump;
      int sent;
      sent = 0;
      while (sent < words) begin
         k   = $urandom_range(0, NUM_KEYS - 1);
         lvl = ($urandom_range(0, 3) != 0) ? ~key_drive[k] : key_drive[k];
         key_drive[k] = lvl;
         len = $urandom_range(1, cur_count + 2);
         case ($urandom_range(0, 5))
            0, 1:    jump = $urandom_range(0, 2 * cur_long + 2);
            2:       jump = $urandom_range(0, 2 * cur_short + 2);
            3:       jump = $urandom;
            4:       jump = $urandom_range(0, 3);
            default: jump = 0;
         endcase
         key_clock[k] = key_clock[k] + jump;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 15) begin
               send_word(key_sample($urandom_range(0, NUM_KEYS - 1),
                                    1'($urandom_range(0, 1)), $urandom));
               sent++;
            end
            send_word(key_sample(k, lvl, key_clock[k]));
            key_clock[k] = key_clock[k] + $urandom_range(0, 1);
            sent++;
         end
      end
   endtask

   initial begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_clock[k] = $urandom;
         key_drive[k] = 1'b1;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: four equal samples after the change accept the level.
      for (int i = 0; i < 5; i++) begin
         send_word(key_sample(2, 1'b1, 32'd1000 + i));
      end

      // A stable count of zero behaves as one.
      program_regs(4'd0, 16'd50, 16'd500);
      send_word(key_sample(0, 1'b0, 32'd0));
      send_word(key_sample(0, 1'b0, 32'd10));
      // Level held stable: accepted again with no edge.
      send_word(key_sample(0, 1'b0, 32'd20));
      send_word(key_sample(0, 1'b1, 32'd30));
      // Duration equal to the short threshold is not a short press.
      send_word(key_sample(0, 1'b1, 32'd50));
      send_word(key_sample(0, 1'b0, 32'd100));
      send_word(key_sample(0, 1'b0, 32'd100));
      send_word(key_sample(0, 1'b1, 32'd500));
      // Duration equal to the long threshold is neither short nor long.
      send_word(key_sample(0, 1'b1, 32'd600));
      // Timestamp wrapping between press and release.
      send_word(key_sample(7, 1'b0, 32'hFFFF_FFF0));
      send_word(key_sample(7, 1'b0, 32'hFFFF_FFF0));
      send_word(key_sample(7, 1'b1, 32'h0000_0050));
      send_word(key_sample(7, 1'b1, 32'h0000_0100));
      // Longest possible duration.
      send_word(key_sample(7, 1'b0, 32'h0000_0000));
      send_word(key_sample(7, 1'b0, 32'h0000_0000));
      send_word(key_sample(7, 1'b1, 32'hFFFF_FFFF));
      send_word(key_sample(7, 1'b1, 32'hFFFF_FFFF));
      // Interleaved keys right behind each other.
      send_word(key_sample(3, 1'b0, 32'd5));
      send_word(key_sample(4, 1'b0, 32'd5));
      send_word(key_sample(3, 1'b0, 32'd6));
      send_word(key_sample(4, 1'b0, 32'd7));

      program_regs(4'd15, 16'd0, 16'hFFFF);
      tx_idle_pct = 30;
      rx_idle_pct = 60;
      random_phase(PHASE_WORDS);

      // Short threshold above the long one: no short press is possible.
      program_regs(4'd1, 16'hFFFF, 16'd0);
      tx_idle_pct = 60;
      rx_idle_pct = 30;
      random_phase(PHASE_WORDS);

      program_regs(4'd2, 16'd50, 16'd500);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_request++;
      random_phase(PHASE_WORDS);

      program_regs(4'($urandom_range(0, 15)), 16'($urandom_range(0, 300)),
                   16'($urandom_range(0, 2000)));
      tx_idle_pct = 30;
      rx_idle_pct = 60;
      random_phase(PHASE_WORDS);

      program_regs(4'd4, 16'd100, 16'd300);
      tx_idle_pct = 60;
      rx_idle_pct = 30;
      random_phase(PHASE_WORDS);

      program_regs(4'd3, 16'($urandom), 16'($urandom));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_phase(PHASE_WORDS);

      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
